// ===== rtl/core/tqs_pkg.sv =====
// Types, constants and helper functions shared by the thread queue scheduler.
package tqs_pkg;

   localparam int THREAD_SLOTS = 16;
   localparam int SLOT_W       = $clog2(THREAD_SLOTS);
   localparam int LINK_W       = $clog2(THREAD_SLOTS + 1);

   // null marker for links, heads, tails and the running slot
   localparam logic [LINK_W-1:0] NIL = LINK_W'(THREAD_SLOTS);

   localparam logic [31:0] STACK_BASE_RESET = 32'h0003_0000;
   localparam int          STACK_SHIFT      = 12;
   localparam logic [31:0] PC_STEP          = 32'd4;

   typedef enum logic [1:0] {
      ACT_CREATE,
      ACT_SCHEDULE,
      ACT_WAKE,
      ACT_INVALID
   } action_type;

   typedef enum logic [1:0] {
      REQ_RUN,
      REQ_SLEEP,
      REQ_INIT,
      REQ_INVALID
   } req_state_type;

   typedef enum logic [1:0] {
      TAG_NONE,
      TAG_FREE,
      TAG_RUN,
      TAG_SLEEP
   } list_tag_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_NO_FREE,
      ST_BAD_STATE,
      ST_BAD_ID,
      ST_NOT_ASLEEP,
      ST_KEPT,
      ST_NONE_RUNNING
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_DET_RD,
      SEQ_DET_P,
      SEQ_DET_N,
      SEQ_LINK_S,
      SEQ_LINK_NB,
      SEQ_POP,
      SEQ_FIN
   } seq_state_type;

   typedef struct packed {
      logic [LINK_W-1:0] next;
      logic [LINK_W-1:0] prev;
      list_tag_type      tag;
   } slot_entry_type;

   function automatic logic link_valid(input logic [LINK_W-1:0] link);
      return link < LINK_W'(THREAD_SLOTS);
   endfunction

   // slots 1..N-1 chained on the free list, slot 0 on no list
   function automatic slot_entry_type slot_reset(input int unsigned idx);
      slot_entry_type e;
      e.next = (idx >= 1 && idx < THREAD_SLOTS - 1) ? LINK_W'(idx + 1) : NIL;
      e.prev = (idx >= 2) ? LINK_W'(idx - 1) : NIL;
      e.tag  = (idx == 0) ? TAG_NONE : TAG_FREE;
      return e;
   endfunction

endpackage

// ===== rtl/core/thread_queue_scheduler.sv =====
// Thread queue scheduler: free, run and sleep slot lists walked by a small sequencer.
// List edits write one slot table entry per sequencer state.
// Throughput: one request at a time; req_stall stays high until the sequencer is back in
// idle, which it enters as the response register loads (a stalled response delays the load).
// Reset (sync, active high): slots 1..N-1 free, other lists empty, base 0x30000, no response.
module thread_queue_scheduler (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_start_address,
   input  logic [1:0]  req_requested_state,
   input  logic [5:0]  req_target_thread,
   input  logic [31:0] req_wake_value,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_thread_id,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_stack_top,
   output logic [31:0] rsp_entry_pc,
   output logic [31:0] rsp_return_value,
   // stack base register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);
   import tqs_pkg::*;

   // sequencer and list heads
   seq_state_type     state_ff, state_in;
   logic [LINK_W-1:0] free_head_ff, free_head_in, free_tail_ff, free_tail_in;
   logic [LINK_W-1:0] run_head_ff, run_head_in, run_tail_ff, run_tail_in;
   logic [LINK_W-1:0] sleep_head_ff, sleep_head_in, sleep_tail_ff, sleep_tail_in;
   logic [LINK_W-1:0] running_ff, running_in;

   // slot link table: one read address (slot_ff), one write per cycle
   slot_entry_type    slots_ff [THREAD_SLOTS];
   slot_entry_type    rd_entry;
   logic              wr_en, wr_next_en, wr_prev_en, wr_tag_en;
   logic [SLOT_W-1:0] wr_addr;
   slot_entry_type    wr_entry;

   // per-request working registers
   logic [SLOT_W-1:0] slot_ff, slot_in;
   list_tag_type      list_ff, list_in;
   logic              at_tail_ff, at_tail_in;
   action_type        action_ff, action_in;
   status_type        status_ff, status_in;
   logic [LINK_W-1:0] p_ff, p_in, n_ff, n_in, nb_ff, nb_in;
   logic [31:0]       epc_ff, epc_in, wval_ff, wval_in;

   logic [31:0]       stack_base_ff;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        rsp_thread_id_ff, rsp_thread_id_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [31:0]       rsp_stack_top_ff, rsp_stack_top_in;
   logic [31:0]       rsp_entry_pc_ff, rsp_entry_pc_in;
   logic [31:0]       rsp_return_value_ff, rsp_return_value_in;

   // selected list head/tail and their updates
   logic [LINK_W-1:0] cur_head, cur_tail, new_head, new_tail, nb;
   logic              set_head, set_tail;

   // shared 32-bit adder: entry pc at request transfer, stack top at finish
   logic [31:0]       add_a, add_b, add_sum;

   req_state_type     req_kind;
   logic              target_ok;

   assign req_kind  = req_state_type'(req_requested_state);
   assign target_ok = {1'b0, req_target_thread} < 7'(THREAD_SLOTS);
   assign rd_entry  = slots_ff[slot_ff];

   assign add_a   = (state_ff == SEQ_IDLE) ? req_start_address : stack_base_ff;
   assign add_b   = (state_ff == SEQ_IDLE) ? PC_STEP
                                           : (32'(slot_ff) + 32'd1) << STACK_SHIFT;
   assign add_sum = add_a + add_b;

   always_comb begin
      case (list_ff)
         TAG_FREE: begin
            cur_head = free_head_ff;
            cur_tail = free_tail_ff;
         end
         TAG_SLEEP: begin
            cur_head = sleep_head_ff;
            cur_tail = sleep_tail_ff;
         end
         default: begin
            cur_head = run_head_ff;
            cur_tail = run_tail_ff;
         end
      endcase
   end

   // sequencer: next state, table write port, list edits, response load
   always_comb begin
      state_in            = state_ff;
      running_in          = running_ff;
      slot_in             = slot_ff;
      list_in             = list_ff;
      at_tail_in          = at_tail_ff;
      action_in           = action_ff;
      status_in           = status_ff;
      p_in                = p_ff;
      n_in                = n_ff;
      nb_in               = nb_ff;
      epc_in              = epc_ff;
      wval_in             = wval_ff;
      wr_en               = 1'b0;
      wr_next_en          = 1'b0;
      wr_prev_en          = 1'b0;
      wr_tag_en           = 1'b0;
      wr_addr             = slot_ff;
      wr_entry            = '{next: NIL, prev: NIL, tag: TAG_NONE};
      set_head            = 1'b0;
      set_tail            = 1'b0;
      new_head            = NIL;
      new_tail            = NIL;
      nb                  = at_tail_ff ? cur_tail : cur_head;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_thread_id_in    = rsp_thread_id_ff;
      rsp_status_in       = rsp_status_ff;
      rsp_stack_top_in    = rsp_stack_top_ff;
      rsp_entry_pc_in     = rsp_entry_pc_ff;
      rsp_return_value_in = rsp_return_value_ff;

      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               action_in  = action_type'(req_action);
               epc_in     = add_sum;
               wval_in    = req_wake_value;
               status_in  = ST_OK;
               slot_in    = '0;
               at_tail_in = 1'b0;
               state_in   = SEQ_FIN;
               unique case (action_type'(req_action))
                  ACT_CREATE: begin
                     if (link_valid(free_head_ff)) begin
                        slot_in  = free_head_ff[SLOT_W-1:0];
                        list_in  = TAG_FREE;
                        state_in = SEQ_DET_RD;
                     end else begin
                        status_in = ST_NO_FREE;
                     end
                  end
                  ACT_SCHEDULE: begin
                     if (req_kind == REQ_INVALID) begin
                        status_in = ST_BAD_STATE;
                     end else if (req_kind == REQ_RUN && !link_valid(run_head_ff)) begin
                        // nothing else to run: keep the current thread
                        if (link_valid(running_ff)) begin
                           status_in = ST_KEPT;
                           slot_in   = running_ff[SLOT_W-1:0];
                        end else begin
                           status_in = ST_NONE_RUNNING;
                        end
                     end else begin
                        if (req_kind != REQ_INIT && !link_valid(running_ff)) begin
                           status_in = ST_NONE_RUNNING;
                        end
                        // requeue the outgoing thread unless idle, absent or init
                        if (req_kind != REQ_INIT && link_valid(running_ff) &&
                            running_ff != '0) begin
                           slot_in    = running_ff[SLOT_W-1:0];
                           list_in    = (req_kind == REQ_RUN) ? TAG_RUN : TAG_SLEEP;
                           at_tail_in = 1'b1;
                           state_in   = SEQ_LINK_S;
                        end else begin
                           state_in = SEQ_POP;
                        end
                     end
                  end
                  ACT_WAKE: begin
                     if (target_ok) begin
                        slot_in  = req_target_thread[SLOT_W-1:0];
                        list_in  = TAG_SLEEP;
                        state_in = SEQ_DET_RD;
                     end else begin
                        status_in = ST_BAD_ID;
                     end
                  end
                  default: begin
                     status_in = ST_BAD_STATE;
                  end
               endcase
            end
         end

         // detach, first step: grab neighbors and clear the slot
         SEQ_DET_RD: begin
            if (action_ff == ACT_WAKE && rd_entry.tag != TAG_SLEEP) begin
               status_in = ST_NOT_ASLEEP;
               state_in  = SEQ_FIN;
            end else begin
               p_in       = rd_entry.prev;
               n_in       = rd_entry.next;
               wr_en      = 1'b1;
               wr_next_en = 1'b1;
               wr_prev_en = 1'b1;
               wr_tag_en  = 1'b1;
               state_in   = SEQ_DET_P;
            end
         end

         // detach: predecessor side or head, and tail when slot was last
         SEQ_DET_P: begin
            if (link_valid(p_ff)) begin
               wr_en         = 1'b1;
               wr_next_en    = 1'b1;
               wr_addr       = p_ff[SLOT_W-1:0];
               wr_entry.next = n_ff;
            end else begin
               set_head = 1'b1;
               new_head = n_ff;
            end
            if (link_valid(n_ff)) begin
               state_in = SEQ_DET_N;
            end else begin
               set_tail = 1'b1;
               new_tail = p_ff;
               if (action_ff == ACT_SCHEDULE) begin
                  running_in = LINK_W'(slot_ff);
                  state_in   = SEQ_FIN;
               end else begin
                  list_in    = TAG_RUN;
                  at_tail_in = 1'b0;
                  state_in   = SEQ_LINK_S;
               end
            end
         end

         // detach: successor side
         SEQ_DET_N: begin
            wr_en         = 1'b1;
            wr_prev_en    = 1'b1;
            wr_addr       = n_ff[SLOT_W-1:0];
            wr_entry.prev = p_ff;
            if (action_ff == ACT_SCHEDULE) begin
               running_in = LINK_W'(slot_ff);
               state_in   = SEQ_FIN;
            end else begin
               list_in    = TAG_RUN;
               at_tail_in = 1'b0;
               state_in   = SEQ_LINK_S;
            end
         end

         // link, first step: write the slot itself and move head or tail
         SEQ_LINK_S: begin
            nb_in         = nb;
            wr_en         = 1'b1;
            wr_next_en    = 1'b1;
            wr_prev_en    = 1'b1;
            wr_tag_en     = 1'b1;
            wr_entry.tag  = list_ff;
            wr_entry.next = at_tail_ff ? NIL : cur_head;
            wr_entry.prev = at_tail_ff ? cur_tail : NIL;
            if (link_valid(nb)) begin
               if (at_tail_ff) begin
                  set_tail = 1'b1;
                  new_tail = LINK_W'(slot_ff);
               end else begin
                  set_head = 1'b1;
                  new_head = LINK_W'(slot_ff);
               end
               state_in = SEQ_LINK_NB;
            end else begin
               set_head = 1'b1;
               set_tail = 1'b1;
               new_head = LINK_W'(slot_ff);
               new_tail = LINK_W'(slot_ff);
               state_in = (action_ff == ACT_SCHEDULE) ? SEQ_POP : SEQ_FIN;
            end
         end

         // link: point the old end entry at the new slot
         SEQ_LINK_NB: begin
            wr_en         = 1'b1;
            wr_addr       = nb_ff[SLOT_W-1:0];
            wr_next_en    = at_tail_ff;
            wr_prev_en    = !at_tail_ff;
            wr_entry.next = LINK_W'(slot_ff);
            wr_entry.prev = LINK_W'(slot_ff);
            state_in      = (action_ff == ACT_SCHEDULE) ? SEQ_POP : SEQ_FIN;
         end

         // pick the next thread: run queue head, else the idle thread
         SEQ_POP: begin
            if (link_valid(run_head_ff)) begin
               slot_in  = run_head_ff[SLOT_W-1:0];
               list_in  = TAG_RUN;
               state_in = SEQ_DET_RD;
            end else begin
               slot_in    = '0;
               running_in = '0;
               state_in   = SEQ_FIN;
            end
         end

         // load the response register once it is free
         SEQ_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_thread_id_in    = 4'(slot_ff);
               rsp_status_in       = status_ff;
               rsp_stack_top_in    = (action_ff == ACT_CREATE && status_ff == ST_OK)
                                     ? add_sum : 32'd0;
               rsp_entry_pc_in     = (action_ff == ACT_CREATE && status_ff == ST_OK)
                                     ? epc_ff : 32'd0;
               rsp_return_value_in = (action_ff == ACT_WAKE && status_ff == ST_OK)
                                     ? wval_ff : 32'd0;
               state_in            = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // apply head/tail edits to the selected list
   always_comb begin
      free_head_in  = free_head_ff;
      free_tail_in  = free_tail_ff;
      run_head_in   = run_head_ff;
      run_tail_in   = run_tail_ff;
      sleep_head_in = sleep_head_ff;
      sleep_tail_in = sleep_tail_ff;
      case (list_ff)
         TAG_FREE: begin
            if (set_head) free_head_in = new_head;
            if (set_tail) free_tail_in = new_tail;
         end
         TAG_SLEEP: begin
            if (set_head) sleep_head_in = new_head;
            if (set_tail) sleep_tail_in = new_tail;
         end
         default: begin
            if (set_head) run_head_in = new_head;
            if (set_tail) run_tail_in = new_tail;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         free_head_ff  <= (THREAD_SLOTS > 1) ? LINK_W'(1) : NIL;
         free_tail_ff  <= (THREAD_SLOTS > 1) ? LINK_W'(THREAD_SLOTS - 1) : NIL;
         run_head_ff   <= NIL;
         run_tail_ff   <= NIL;
         sleep_head_ff <= NIL;
         sleep_tail_ff <= NIL;
         running_ff    <= NIL;
         rsp_valid_ff  <= 1'b0;
         stack_base_ff <= STACK_BASE_RESET;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         free_tail_ff  <= free_tail_in;
         run_head_ff   <= run_head_in;
         run_tail_ff   <= run_tail_in;
         sleep_head_ff <= sleep_head_in;
         sleep_tail_ff <= sleep_tail_in;
         running_ff    <= running_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            stack_base_ff <= csr_wdata;
         end
      end
   end

   // slot link table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < THREAD_SLOTS; i++) begin
            slots_ff[i] <= slot_reset(i);
         end
      end else if (wr_en) begin
         if (wr_next_en) slots_ff[wr_addr].next <= wr_entry.next;
         if (wr_prev_en) slots_ff[wr_addr].prev <= wr_entry.prev;
         if (wr_tag_en)  slots_ff[wr_addr].tag  <= wr_entry.tag;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      slot_ff             <= slot_in;
      list_ff             <= list_in;
      at_tail_ff          <= at_tail_in;
      action_ff           <= action_in;
      status_ff           <= status_in;
      p_ff                <= p_in;
      n_ff                <= n_in;
      nb_ff               <= nb_in;
      epc_ff              <= epc_in;
      wval_ff             <= wval_in;
      rsp_thread_id_ff    <= rsp_thread_id_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_stack_top_ff    <= rsp_stack_top_in;
      rsp_entry_pc_ff     <= rsp_entry_pc_in;
      rsp_return_value_ff <= rsp_return_value_in;
   end

   assign req_stall        = (state_ff != SEQ_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_thread_id    = rsp_thread_id_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_stack_top    = rsp_stack_top_ff;
   assign rsp_entry_pc     = rsp_entry_pc_ff;
   assign rsp_return_value = rsp_return_value_ff;

   // the running thread is never also on a list
   a_running_unlisted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_IDLE && running_ff < LINK_W'(THREAD_SLOTS)) |->
      (slots_ff[running_ff[SLOT_W-1:0]].tag == TAG_NONE))
      else $error("running thread still tagged on a list");

   // run queue head and tail are empty together
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_IDLE) |->
      ((run_head_ff < LINK_W'(THREAD_SLOTS)) == (run_tail_ff < LINK_W'(THREAD_SLOTS))))
      else $error("run queue head and tail disagree on emptiness");

   // free list head really is a free slot
   a_free_head_tag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_IDLE && free_head_ff < LINK_W'(THREAD_SLOTS)) |->
      (slots_ff[free_head_ff[SLOT_W-1:0]].tag == TAG_FREE))
      else $error("free list head not tagged free");

   // a taken response is not shown again unless a new one was loaded
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && state_ff != SEQ_FIN) |=> !rsp_valid_ff)
      else $error("response repeated after transfer");

endmodule
